// ----- hw/rtl/pip_pkg.sv -----
// Shared types and constants for the point-in-polygon tester.
package pip_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned DIFF_W  = COORD_W + 1;
    localparam int unsigned PROD_W  = 2 * COORD_W;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned MIN_VERTS = 3;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_TEST   = 2'd2;

    typedef struct packed {
        logic op_clear;
        logic op_append;
        logic test_start;
        logic rd_en;
        logic rd_first;
        logic out_load;
        logic out_short;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic out_full;
        logic few;
    } t_status;

endpackage

// ----- hw/rtl/pip_ctrl.sv -----
// Controller: opcode decode and the edge walk sequencer.
module pip_ctrl #(
    parameter int unsigned MAX_VERTICES = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic [pip_pkg::OP_W-1:0]          i_opcode,
    output logic                              o_in_ready,
    output pip_pkg::t_cmd                     o_cmd,
    output logic [$clog2(MAX_VERTICES)-1:0]   o_rd_addr,
    input  pip_pkg::t_status                  i_status,
    input  logic [$clog2(MAX_VERTICES)-1:0]   i_last_addr
);

    localparam int unsigned AW = $clog2(MAX_VERTICES);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_VJ     = 5'b00010,
        ST_WALK   = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_FINISH = 5'b10000
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_idx, n_idx;
    logic            r_short, n_short;
    logic            w_accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_short   = r_short;
        o_cmd     = '0;
        o_rd_addr = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_opcode)
                        pip_pkg::OP_CLEAR:  o_cmd.op_clear  = 1'b1;
                        pip_pkg::OP_APPEND: o_cmd.op_append = 1'b1;
                        pip_pkg::OP_TEST: begin
                            o_cmd.test_start = 1'b1;
                            n_short = i_status.few;
                            n_state = i_status.few ? ST_FINISH : ST_VJ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_VJ: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_first = 1'b1;
                o_rd_addr      = i_last_addr;
                n_idx          = '0;
                n_state        = ST_WALK;
            end
            ST_WALK: begin
                o_cmd.rd_en = 1'b1;
                n_idx       = r_idx + AW'(1);
                if (r_idx == i_last_addr) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_status.busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!i_status.out_full) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_short = r_short;
                    n_state         = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_short <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_short <= n_short;
        end
    end

endmodule

// ----- hw/rtl/pip_dpath.sv -----
// Datapath: vertex memory, crossing pipeline, parity and result register.
module pip_dpath #(
    parameter int unsigned MAX_VERTICES = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  pip_pkg::t_cmd                          i_cmd,
    input  logic [$clog2(MAX_VERTICES)-1:0]        i_rd_addr,
    input  logic signed [pip_pkg::COORD_W-1:0]     i_x,
    input  logic signed [pip_pkg::COORD_W-1:0]     i_y,
    output pip_pkg::t_status                       o_status,
    output logic [$clog2(MAX_VERTICES)-1:0]        o_last_addr,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic                                   o_out_inside,
    output logic                                   o_out_pvalid
);

    localparam int unsigned AW = $clog2(MAX_VERTICES);
    localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
    localparam int unsigned C
        = pip_pkg::COORD_W;
    localparam int unsigned DW = pip_pkg::DIFF_W;
    localparam int unsigned PW = pip_pkg::PROD_W;

    // vertex store: {y, x}
    logic [2*C-1:0]  r_mem [MAX_VERTICES];
    logic [2*C-1:0]  r_rd;
    logic [CW-1:0]   r_count;

    logic signed [C-1:0] r_px, r_py;

    // stage 1: read data
    logic            r_v1, r_f1;
    logic signed [C-1:0] r_jx, r_jy;
    logic signed [C-1:0] w_ix, w_iy;

    // stage 2: differences
    logic            r_v2, r_c2;
    logic signed [DW-1:0] r_d, r_lx, r_rx, r_ry;

    // stage 3: magnitudes and signs
    logic            r_v3, r_c3, r_ln3, r_rn3;
    logic [C-1:0]    r_md, r_mlx, r_mrx, r_mry;

    // stage 4: products
    logic            r_v4, r_c4, r_ln4, r_rn4;
    logic [PW-1:0]   r_lm, r_rm;

    logic            r_parity;
    logic            w_an, w_bn, w_less;

    function automatic logic [pip_pkg::COORD_W-1:0] mag(
        input logic signed [pip_pkg::DIFF_W-1:0] v
    );
        logic [pip_pkg::DIFF_W-1:0] t;
        t = v[pip_pkg::DIFF_W-1] ? (~v + 1'b1) : v;
        return t[pip_pkg::COORD_W-1:0];
    endfunction

    assign o_last_addr     = AW'(r_count - CW'(1));
    assign o_status.few    = (r_count < CW'(pip_pkg::MIN_VERTS));
    assign o_status.busy   = r_v1 | r_v2 | r_v3 | r_v4;
    assign o_status.out_full = o_out_valid;

    assign w_ix = r_rd[C-1:0];
    assign w_iy = r_rd[2*C-1:C];

    always_ff @(posedge i_clk) begin
        if (i_cmd.op_append && (r_count < CW'(MAX_VERTICES))) begin
            r_mem[r_count[AW-1:0]] <= {i_y, i_x};
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.op_clear) begin
            r_count <= '0;
        end else if (i_cmd.op_append && (r_count < CW'(MAX_VERTICES))) begin
            r_count <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.test_start) begin
            r_px <= i_x;
            r_py <= i_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1 && !r_f1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1 <= i_cmd.rd_first;
        if (r_v1) begin
            r_jx <= w_ix;
            r_jy <= w_iy;
        end
        // edge from vertex i (this read) to vertex j (previous read)
        r_c2 <= (w_iy > r_py) != (r_jy > r_py);
        r_d  <= DW'(r_jy) - DW'(w_iy);
        r_lx <= DW'(r_px) - DW'(w_ix);
        r_rx <= DW'(r_jx) - DW'(w_ix);
        r_ry <= DW'(r_py) - DW'(w_iy);

        r_c3  <= r_c2;
        r_ln3 <= r_lx[DW-1];
        r_rn3 <= r_rx[DW-1] ^ r_ry[DW-1] ^ r_d[DW-1];
        r_md  <= mag(r_d);
        r_mlx <= mag(r_lx);
        r_mrx <= mag(r_rx);
        r_mry <= mag(r_ry);

        r_c4  <= r_c3;
        r_ln4 <= r_ln3;
        r_rn4 <= r_rn3;
        r_lm  <= PW'(r_mlx) * PW'(r_md);
        r_rm  <= PW'(r_mrx) * PW'(r_mry);
    end

    // signed compare in sign/magnitude form, zero has no sign
    assign w_an   = r_ln4 && (r_lm != '0);
    assign w_bn   = r_rn4 && (r_rm != '0);
    assign w_less = (w_an && !w_bn) || (!w_an && !w_bn && (r_lm < r_rm))
                  || (w_an && w_bn && (r_lm > r_rm));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity <= 1'b0;
        end else if (i_cmd.test_start) begin
            r_parity <= 1'b0;
        end else if (r_v4 && r_c4 && w_less) begin
            r_parity <= ~r_parity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_inside <= i_cmd.out_short ? 1'b0 : r_parity;
            o_out_pvalid <= ~i_cmd.out_short;
        end
    end

endmodule

// ----- hw/rtl/point_in_polygon_test.sv -----
// Point-in-polygon tester (even-odd ray casting), top level.
// Clear and append do not leave the idle state; a new beat is taken the next cycle.
// A test on n >= 3 vertices reads the last vertex, then one vertex memory read per edge, through
// a four-stage crossing pipeline; with fewer vertices the result is given without a walk.
// After a test the next beat is taken once the result is loaded, later while a result still waits.
// Synchronous active-low reset empties the polygon and the result register.
module point_in_polygon_test #(
    parameter int unsigned MAX_VERTICES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [31:0] coord_x, [63:32] coord_y
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [0] inside_res, [7:1] zero
    output logic [0:0]  o_m_axis_tuser    // [0] polygon_valid
);

    localparam int unsigned AW = $clog2(MAX_VERTICES);

    pip_pkg::t_cmd    w_cmd;
    pip_pkg::t_status w_status;
    logic [AW-1:0]    w_rd_addr;
    logic [AW-1:0]    w_last_addr;
    logic             w_inside;
    logic             w_pvalid;

    pip_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_opcode    (i_s_axis_tuser),
        .o_in_ready  (o_s_axis_tready),
        .o_cmd       (w_cmd),
        .o_rd_addr   (w_rd_addr),
        .i_status    (w_status),
        .i_last_addr (w_last_addr)
    );

    pip_dpath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_rd_addr    (w_rd_addr),
        .i_x          (i_s_axis_tdata[31:0]),
        .i_y          (i_s_axis_tdata[63:32]),
        .o_status     (w_status),
        .o_last_addr  (w_last_addr),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_out_inside (w_inside),
        .o_out_pvalid (w_pvalid)
    );

    assign o_m_axis_tdata = {7'd0, w_inside};
    assign o_m_axis_tuser = w_pvalid;

endmodule

// ----- tb/pip_checker.sv -----
// Beat monitor, polygon predictor and result scoreboard for point_in_polygon_test.
module pip_checker #(
    parameter int unsigned MAX_VERTICES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [63:0] i_s_tdata,   // [31:0] coord_x, [63:32] coord_y
    input  logic [1:0]  i_s_tuser,   // [1:0] opcode
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,   // [0] inside_res, [7:1] zero
    input  logic [0:0]  i_m_tuser,   // [0] polygon_valid
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct {
        logic in_poly;
        logic poly_ok;
    } t_verdict;

    logic signed [pip_pkg::COORD_W-1:0] poly_x [MAX_VERTICES];
    logic signed [pip_pkg::COORD_W-1:0] poly_y [MAX_VERTICES];
    int unsigned               poly_count;
    t_verdict                  verdicts [$];

    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Exact crossing test of the +x ray from (px, py) against edge i-j.
    function automatic bit ray_crosses(longint px, longint py, longint xi, longint yi,
                                       longint xj, longint yj);
        longint      dy, lx, rx, ry;
        bit          lneg, rneg;
        logic [63:0] lmag, rmag;
        if ((yi > py) == (yj > py))
            return 1'b0;
        dy   = yj - yi;
        lx   = px - xi;
        rx   = xj - xi;
        ry   = py - yi;
        lneg = (lx < 0);
        lmag = magnitude(lx) * magnitude(dy);
        rneg = (rx < 0) != (ry < 0);
        if (dy < 0)
            rneg = !rneg;
        rmag = magnitude(rx) * magnitude(ry);
        if (lmag == 0)
            lneg = 1'b0;
        if (rmag == 0)
            rneg = 1'b0;
        if (lneg != rneg)
            return lneg;
        return lneg ? (lmag > rmag) : (lmag < rmag);
    endfunction

    function automatic t_verdict judge_point(longint px, longint py);
        t_verdict    v;
        int unsigned j;
        v.in_poly = 1'b0;
        v.poly_ok = 1'b0;
        if (poly_count < pip_pkg::MIN_VERTS)
            return v;
        v.poly_ok = 1'b1;
        j = poly_count - 1;
        for (int unsigned i = 0; i < poly_count; i++) begin
            if (ray_crosses(px, py, longint'(poly_x[i]), longint'(poly_y[i]),
                            longint'(poly_x[j]), longint'(poly_y[j])))
                v.in_poly = !v.in_poly;
            j = i;
        end
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            poly_count = 0;
            verdicts.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (verdicts.size() == 0) begin
                    $error("result beat with no test pending");
                    o_fail_count++;
                end else begin
                    want = verdicts.pop_front();
                    if (i_m_tdata[0] !== want.in_poly) begin
                        $error("inside_res: expected %0b, got %0b", want.in_poly, i_m_tdata[0]);
                        o_fail_count++;
                    end
                    if (i_m_tuser[0] !== want.poly_ok) begin
                        $error("polygon_valid: expected %0b, got %0b",
                               want.poly_ok, i_m_tuser[0]);
                        o_fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                case (i_s_tuser)
                    pip_pkg::OP_CLEAR: begin
                        poly_count = 0;
                    end
                    pip_pkg::OP_APPEND: begin
                        if (poly_count < MAX_VERTICES) begin
                            poly_x[poly_count] = $signed(i_s_tdata[31:0]);
                            poly_y[poly_count] = $signed(i_s_tdata[63:32]);
                            poly_count++;
                        end
                    end
                    pip_pkg::OP_TEST: begin
                        verdicts.push_back(judge_point(longint'($signed(i_s_tdata[31:0])),
                                                       longint'($signed(i_s_tdata[63:32]))));
                    end
                    default: ;
                endcase
            end
        end
        o_pending = verdicts.size();
    end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for point_in_polygon_test: clock, reset, stimulus and verdict.
module tb_top;

    localparam int unsigned       MAX_VERTS = 32;
    localparam logic [pip_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;
    localparam logic signed [31:0] CMIN = 32'sh8000_0000;
    localparam logic signed [31:0] CMAX = 32'sh7fff_ffff;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    int          fail_count;
    int          results_pending;

    int burst_left;
    int held;
    int n_sent;

    point_in_polygon_test #(
        .MAX_VERTICES(MAX_VERTS)
    ) u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tuser (m_tuser)
    );

    pip_checker #(
        .MAX_VERTICES(MAX_VERTS)
    ) u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .o_fail_count(fail_count),
        .o_pending   (results_pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic signed [31:0] rand_coord(int scale);
        int v;
        case (scale)
            0: begin
                v = (int'($urandom_range(0, 32)) - 16) * 65536;
                if ($urandom_range(0, 1))
                    v += int'($urandom_range(0, 65535));
                return v;
            end
            1: return $signed($urandom) >>> 11;
            2: return $urandom;
            default: begin
                case ($urandom_range(0, 5))
                    0: return CMIN;
                    1: return CMAX;
                    2: return 0;
                    3: return -1;
                    4: return 1;
                    default: return ONE;
                endcase
            end
        endcase
    endfunction

    // Offers one beat at a falling edge and returns at the falling edge after it is taken.
    task automatic send_item(logic [1:0] op, logic signed [31:0] x, logic signed [31:0] y);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        case (op)
            pip_pkg::OP_CLEAR: begin
                held = 0;
                n_sent++;
            end
            pip_pkg::OP_APPEND: begin
                if (held < MAX_VERTS) begin
                    held++;
                    n_sent++;
                end
            end
            pip_pkg::OP_TEST: n_sent++;
            default: ;
        endcase
    endtask

    // Receiver stall pattern, with one long hold-off that backs the block up.
    initial begin
        int mode, span, elapsed;
        bit long_hold_done;
        m_tready = 1'b0;
        elapsed = 0;
        long_hold_done = 1'b0;
        wait (rst_n);
        forever begin
            if (!long_hold_done && elapsed >= 3000) begin
                long_hold_done = 1'b1;
                repeat (600) begin
                    @(negedge clk);
                    m_tready <= 1'b0;
                end
            end
            mode = $urandom_range(0, 9);
            span = $urandom_range(10, 150);
            elapsed += span;
            repeat (span) begin
                @(negedge clk);
                case (mode)
                    0, 1, 2, 3: m_tready <= 1'b1;
                    4, 5, 6:    m_tready <= 1'($urandom_range(0, 1));
                    7, 8:       m_tready <= ($urandom_range(0, 3) == 0);
                    default:    m_tready <= 1'b0;
                endcase
            end
        end
    end

    initial begin
        int scale, pick, k, idx;
        logic signed [31:0] x, y;
        logic signed [31:0] vx_list [$];
        logic signed [31:0] vy_list [$];

        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = pip_pkg::OP_CLEAR;
        burst_left = 0;
        held       = 0;
        n_sent     = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // too few vertices
        send_item(pip_pkg::OP_TEST, 0, 0);
        send_item(pip_pkg::OP_APPEND, 0, 0);
        send_item(pip_pkg::OP_TEST, 0, 0);
        send_item(pip_pkg::OP_APPEND, 4 * ONE, 0);
        send_item(pip_pkg::OP_TEST, ONE, 0);
        // unit-scale square, interior, exterior and boundary points
        send_item(pip_pkg::OP_CLEAR, 0, 0);
        send_item(pip_pkg::OP_APPEND, 0, 0);
        send_item(pip_pkg::OP_APPEND, 4 * ONE, 0);
        send_item(pip_pkg::OP_APPEND, 4 * ONE, 4 * ONE);
        send_item(pip_pkg::OP_APPEND, 0, 4 * ONE);
        send_item(pip_pkg::OP_TEST, 2 * ONE, 2 * ONE);
        send_item(pip_pkg::OP_TEST, 5 * ONE, 2 * ONE);
        send_item(pip_pkg::OP_TEST, 0, 2 * ONE);
        send_item(pip_pkg::OP_TEST, 2 * ONE, 0);
        // full-range square
        send_item(pip_pkg::OP_CLEAR, 0, 0);
        send_item(pip_pkg::OP_APPEND, CMIN, CMIN);
        send_item(pip_pkg::OP_APPEND, CMAX, CMIN);
        send_item(pip_pkg::OP_APPEND, CMAX, CMAX);
        send_item(pip_pkg::OP_APPEND, CMIN, CMAX);
        send_item(pip_pkg::OP_TEST, 0, 0);
        send_item(pip_pkg::OP_TEST, CMIN, 0);
        send_item(pip_pkg::OP_TEST, CMAX - 1, CMAX - 1);
        send_item(OP_UNUSED, -1, -1);

        s_tvalid <= 1'b0;
        wait (results_pending == 0);
        @(negedge clk);

        while (n_sent < 1300) begin
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
                idx = $urandom_range(0, 19);
                scale = (idx < 8) ? 0 : (idx < 13) ? 1 : (idx < 18) ? 2 : 3;
                k = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 36)
                                                : $urandom_range(3, 12);
                send_item(pip_pkg::OP_CLEAR, rand_coord(2), rand_coord(2));
                vx_list.delete();
                vy_list.delete();
                repeat (k) begin
                    x = rand_coord(scale);
                    y = rand_coord(scale);
                    vx_list.push_back(x);
                    vy_list.push_back(y);
                    send_item(pip_pkg::OP_APPEND, x, y);
                end
                repeat ($urandom_range(1, 8)) begin
                    idx = $urandom_range(0, vx_list.size() - 1);
                    case ($urandom_range(0, 7))
                        0, 1: begin
                            x = rand_coord(scale);
                            y = vy_list[idx];
                        end
                        2: begin
                            x = vx_list[idx];
                            y = vy_list[idx];
                        end
                        3: begin
                            x = vx_list[idx];
                            y = rand_coord(scale);
                        end
                        default: begin
                            x = rand_coord(scale);
                            y = rand_coord(scale);
                        end
                    endcase
                    send_item(pip_pkg::OP_TEST, x, y);
                end
            end else begin
                // degenerate polygon, then raw beats with any opcode
                send_item(pip_pkg::OP_CLEAR, rand_coord(2), rand_coord(2));
                repeat ($urandom_range(0, 2))
                    send_item(pip_pkg::OP_APPEND, rand_coord(2), rand_coord(2));
                send_item(pip_pkg::OP_TEST, rand_coord(2), rand_coord(2));
                repeat ($urandom_range(1, 3))
                    send_item(2'($urandom_range(0, 3)), rand_coord(2), rand_coord(2));
            end
            if ($urandom_range(0, 24) == 0) begin
                s_tvalid <= 1'b0;
                wait (results_pending == 0);
                @(negedge clk);
            end
        end

        s_tvalid <= 1'b0;
        wait (results_pending == 0);
        repeat (64) @(posedge clk);
        if (fail_count == 0 && results_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
